[hdl/rfdt_pkg.sv]
package rfdt_pkg;

	localparam int TableDepth = 1024;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = IdxW + 1;
	localparam int MaxLen = 32;
	localparam int LenSteps = 33;
	localparam int Buckets = LenSteps * LenSteps * 4;
	localparam int BktW = 13;
	localparam int BcntW = 16;
	localparam int DistW = 11;
	localparam int EntryW = 32 + 6 + 32 + 6 + 32 + 32 + 16;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_step;
		logic bkt_rd;
		logic bkt_wr;
		logic scan_rd;
		logic scan_cmp;
		logic commit;
		logic out_load;
	} rfdt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic scan_last;
		logic scan_empty;
	} rfdt_sts_t;

	// clamp a 6-bit length to 32
	function automatic logic [5:0] clamp_len(input logic [5:0] v);
		return (v > 6'(MaxLen)) ? 6'(MaxLen) : v;
	endfunction

	// prefix compare with equal lengths required
	function automatic logic prefix_match(input logic [31:0] a_addr, input logic [5:0] a_len,
			input logic [31:0] b_addr, input logic [5:0] b_len);
		logic [31:0] mask;
		mask = (a_len == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - a_len));
		return (a_len == b_len) && ((a_addr & mask) == (b_addr & mask));
	endfunction

endpackage

[hdl/rfdt_ctrl.sv]
module rfdt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rfdt_pkg::rfdt_sts_t sts,
	output rfdt_pkg::rfdt_cmd_t cmd
);

	typedef enum logic [2:0] {
		CLEAR, IDLE, BKT, SCAN, CMP_LAST, COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// output register frees when taken
	logic out_free;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			CLEAR: cmd.clr_step = 1'b1;
			IDLE: cmd.load = in_valid;
			BKT: begin
				cmd.bkt_rd = 1'b1;
				cmd.scan_rd = 1'b1;
			end
			SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.scan_cmp = 1'b1;
			end
			CMP_LAST: cmd.scan_cmp = 1'b1;
			COMMIT: begin
				cmd.bkt_wr = out_free;
				cmd.commit = out_free;
				cmd.out_load = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			// result beat loads on commit, drops when taken
			if (state_q == COMMIT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				CLEAR: if (sts.clr_done) state_q <= IDLE;
				IDLE: if (in_valid) state_q <= BKT;
				BKT: state_q <= sts.scan_empty ? CMP_LAST : (sts.scan_last ? CMP_LAST : SCAN);
				SCAN: if (sts.scan_last) state_q <= CMP_LAST;
				CMP_LAST: state_q <= COMMIT;
				COMMIT: if (out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

[hdl/rfdt_dp.sv]
module rfdt_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rfdt_pkg::rfdt_cmd_t cmd,
	output rfdt_pkg::rfdt_sts_t sts,
	input  logic [31:0]       src_addr,
	input  logic [5:0]        src_len,
	input  logic [31:0]       dst_addr,
	input  logic [5:0]        dst_len,
	input  logic [15:0]       sport_low,
	input  logic [15:0]       sport_high,
	input  logic [15:0]       dport_low,
	input  logic [15:0]       dport_high,
	input  logic [7:0]        proto_low,
	input  logic [7:0]        proto_high,
	output logic [4:0]        new_field_mask,
	output logic [12:0]       bucket_index,
	output logic [15:0]       bucket_count,
	output logic [10:0]       distinct_src,
	output logic [10:0]       distinct_dst,
	output logic [10:0]       distinct_sport,
	output logic [10:0]       distinct_dport,
	output logic [10:0]       distinct_proto,
	output logic              table_full
);

	localparam int IdxW = rfdt_pkg::IdxW;
	localparam int CntW = rfdt_pkg::CntW;
	localparam int BktW = rfdt_pkg::BktW;
	localparam int EW = rfdt_pkg::EntryW;

	// rule table and bucket memory
	logic [EW-1:0] tbl_mem [rfdt_pkg::TableDepth];
	logic [rfdt_pkg::BcntW-1:0] bkt_mem [rfdt_pkg::Buckets];

	// latched rule
	logic [31:0] s_addr_q, d_addr_q;
	logic [5:0]  s_len_q, d_len_q;
	logic [15:0] sp_lo_q, sp_hi_q, dp_lo_q, dp_hi_q;
	logic [7:0]  pr_lo_q, pr_hi_q;
	logic [BktW-1:0] bidx_q;
	logic [CntW-1:0] count_q, scan_q;
	logic [4:0]  seen_q;
	logic [EW-1:0] rd_q;
	logic [rfdt_pkg::BcntW-1:0] bkt_rd_q;
	logic [BktW-1:0] clr_q;
	logic [rfdt_pkg::DistW-1:0] dist_q [5];

	logic [5:0] s_len_c, d_len_c;
	logic [BktW-1:0] bidx_c;
	assign s_len_c = rfdt_pkg::clamp_len(src_len);
	assign d_len_c = rfdt_pkg::clamp_len(dst_len);
	assign bidx_c = BktW'(s_len_c) * BktW'(132) + BktW'(d_len_c) * BktW'(4)
		+ BktW'({(sport_low != sport_high), (dport_low != dport_high)});

	assign sts.clr_done = (clr_q == BktW'(rfdt_pkg::Buckets - 1));
	assign sts.scan_empty = (count_q == '0);
	assign sts.scan_last = (scan_q + CntW'(1) >= count_q);

	// compare of the registered entry against the rule
	logic [4:0] hit;
	always_comb begin
		hit[0] = rfdt_pkg::prefix_match(s_addr_q, s_len_q, rd_q[EW-1 -: 32], rd_q[EW-33 -: 6]);
		hit[1] = rfdt_pkg::prefix_match(d_addr_q, d_len_q, rd_q[EW-39 -: 32], rd_q[EW-71 -: 6]);
		hit[2] = rd_q[79:48] == {sp_lo_q, sp_hi_q};
		hit[3] = rd_q[47:16] == {dp_lo_q, dp_hi_q};
		hit[4] = rd_q[15:0] == {pr_lo_q, pr_hi_q};
	end

	logic [4:0] nmask;
	logic full_c;
	logic [rfdt_pkg::BcntW-1:0] bnext;
	assign nmask = ~seen_q;
	assign full_c = (nmask != '0) && (count_q >= CntW'(rfdt_pkg::TableDepth));
	assign bnext = (bkt_rd_q == '1) ? bkt_rd_q : bkt_rd_q + 1'b1;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.scan_rd)
			rd_q <= tbl_mem[scan_q[IdxW-1:0]];
		if (cmd.bkt_rd)
			bkt_rd_q <= bkt_mem[bidx_q];
		if (cmd.clr_step)
			bkt_mem[clr_q] <= '0;
		else if (cmd.bkt_wr)
			bkt_mem[bidx_q] <= bnext;
		if (cmd.commit && nmask != '0 && !full_c)
			tbl_mem[count_q[IdxW-1:0]] <= {s_addr_q, s_len_q, d_addr_q, d_len_q,
				sp_lo_q, sp_hi_q, dp_lo_q, dp_hi_q, pr_lo_q, pr_hi_q};
	end

	// rule capture and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_addr_q <= src_addr;
			s_len_q <= s_len_c;
			d_addr_q <= dst_addr;
			d_len_q <= d_len_c;
			sp_lo_q <= sport_low;
			sp_hi_q <= sport_high;
			dp_lo_q <= dport_low;
			dp_hi_q <= dport_high;
			pr_lo_q <= proto_low;
			pr_hi_q <= proto_high;
			bidx_q <= bidx_c;
		end
		if (cmd.out_load) begin
			new_field_mask <= nmask;
			bucket_index <= bidx_q;
			bucket_count <= bnext;
			table_full <= full_c;
			distinct_src <= dist_q[0] + ((nmask[0] && !full_c) ? 11'd1 : 11'd0);
			distinct_dst <= dist_q[1] + ((nmask[1] && !full_c) ? 11'd1 : 11'd0);
			distinct_sport <= dist_q[2] + ((nmask[2] && !full_c) ? 11'd1 : 11'd0);
			distinct_dport <= dist_q[3] + ((nmask[3] && !full_c) ? 11'd1 : 11'd0);
			distinct_proto <= dist_q[4] + ((nmask[4] && !full_c) ? 11'd1 : 11'd0);
		end
	end

	// control state: counters, scan pointer, match flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q <= '0;
			seen_q <= '0;
			clr_q <= '0;
			for (int i = 0; i < 5; i++) dist_q[i] <= '0;
		end else begin
			if (cmd.clr_step && !sts.clr_done)
				clr_q <= clr_q + 1'b1;
			if (cmd.load) begin
				scan_q <= '0;
				seen_q <= '0;
			end else if (cmd.scan_rd)
				scan_q <= scan_q + 1'b1;
			if (cmd.scan_cmp && !sts.scan_empty)
				seen_q <= seen_q | hit;
			if (cmd.commit && nmask != '0 && !full_c) begin
				count_q <= count_q + 1'b1;
				for (int i = 0; i < 5; i++)
					if (nmask[i]) dist_q[i] <= dist_q[i] + 1'b1;
			end
		end
	end

endmodule

[hdl/rule_field_distinct_tracker.sv]
// Rule field distinct tracker.
// Input channel (in_valid/in_ready) takes one 5-field classifier rule a beat;
// output channel (out_valid/out_ready) returns one result beat per rule:
// new-field mask, histogram bucket and its count, per-field distinct counts
// and a table-full flag.
// Each rule is compared against every stored rule (up to 1024), one entry per
// cycle from a single-port table memory. One rule is in work at a time; the
// next is accepted once the result is loaded into the output register.
// After reset the 4356-entry bucket memory is cleared, one entry a cycle,
// while in_ready is low. The rule table needs no clearing: only entries
// below the stored count are compared.
// If the receiver stalls, the result holds in the output register and the
// next rule may still be accepted and scanned; it waits for the register
// to free before its own result is loaded.
module rule_field_distinct_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] src_addr,
	input  logic [5:0]  src_len,
	input  logic [31:0] dst_addr,
	input  logic [5:0]  dst_len,
	input  logic [15:0] sport_low,
	input  logic [15:0] sport_high,
	input  logic [15:0] dport_low,
	input  logic [15:0] dport_high,
	input  logic [7:0]  proto_low,
	input  logic [7:0]  proto_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  new_field_mask,
	output logic [12:0] bucket_index,
	output logic [15:0] bucket_count,
	output logic [10:0] distinct_src,
	output logic [10:0] distinct_dst,
	output logic [10:0] distinct_sport,
	output logic [10:0] distinct_dport,
	output logic [10:0] distinct_proto,
	output logic        table_full
);

	rfdt_pkg::rfdt_cmd_t cmd;
	rfdt_pkg::rfdt_sts_t sts;

	rfdt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	rfdt_dp u_dp (
		.clk, .arst_n, .cmd, .sts,
		.src_addr, .src_len, .dst_addr, .dst_len,
		.sport_low, .sport_high, .dport_low, .dport_high,
		.proto_low, .proto_high,
		.new_field_mask, .bucket_index, .bucket_count,
		.distinct_src, .distinct_dst, .distinct_sport, .distinct_dport,
		.distinct_proto, .table_full
	);

endmodule

[tb/sv/rule_field_distinct_tracker_test.sv]
module rule_field_distinct_tracker_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FieldSrc = 0;
	localparam int FieldDst = 1;
	localparam int FieldSport = 2;
	localparam int FieldDport = 3;
	localparam int FieldProto = 4;
	localparam int NumFields = 5;
	localparam int IdleLimit = 20000;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [5:0]  src_len;
		logic [31:0] dst_addr;
		logic [5:0]  dst_len;
		logic [15:0] sport_low;
		logic [15:0] sport_high;
		logic [15:0] dport_low;
		logic [15:0] dport_high;
		logic [7:0]  proto_low;
		logic [7:0]  proto_high;
	} rule_t;

	typedef struct packed {
		logic [4:0]  new_field_mask;
		logic [12:0] bucket_index;
		logic [15:0] bucket_count;
		logic [10:0] distinct_src;
		logic [10:0] distinct_dst;
		logic [10:0] distinct_sport;
		logic [10:0] distinct_dport;
		logic [10:0] distinct_proto;
		logic        table_full;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	rule_t drv;
	logic out_valid;
	logic out_ready;
	verdict_t got;

	// shadow of the rule table and histogram
	rule_t       known_rules[rfdt_pkg::TableDepth];
	int          known_count;
	int unsigned bucket_hist[rfdt_pkg::Buckets];
	int unsigned field_seen[NumFields];
	verdict_t    pending_verdicts[$];

	int  fail_count;
	int  idle_cycles;
	int  stall_left;

	rule_field_distinct_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.src_addr(drv.src_addr),
		.src_len(drv.src_len),
		.dst_addr(drv.dst_addr),
		.dst_len(drv.dst_len),
		.sport_low(drv.sport_low),
		.sport_high(drv.sport_high),
		.dport_low(drv.dport_low),
		.dport_high(drv.dport_high),
		.proto_low(drv.proto_low),
		.proto_high(drv.proto_high),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.new_field_mask(got.new_field_mask),
		.bucket_index(got.bucket_index),
		.bucket_count(got.bucket_count),
		.distinct_src(got.distinct_src),
		.distinct_dst(got.distinct_dst),
		.distinct_sport(got.distinct_sport),
		.distinct_dport(got.distinct_dport),
		.distinct_proto(got.distinct_proto),
		.table_full(got.table_full)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [5:0] sat_len(logic [5:0] v);
		return (v > 6'd32) ? 6'd32 : v;
	endfunction

	function automatic bit prefixes_equal(logic [31:0] a, logic [5:0] al,
			logic [31:0] b, logic [5:0] bl);
		logic [31:0] m;
		if (al != bl)
			return 1'b0;
		if (al == 6'd0)
			return 1'b1;
		m = 32'hFFFF_FFFF << (32 - al);
		return (a & m) == (b & m);
	endfunction

	// classify one rule, update shadow state, return the verdict
	function automatic verdict_t classify_rule(rule_t r);
		verdict_t v;
		logic [4:0] hit;
		int bidx;
		hit = '0;
		r.src_len = sat_len(r.src_len);
		r.dst_len = sat_len(r.dst_len);
		bidx = r.src_len * 132 + r.dst_len * 4
			+ ((r.sport_low != r.sport_high) ? 2 : 0)
			+ ((r.dport_low != r.dport_high) ? 1 : 0);
		if (bucket_hist[bidx] < 65535)
			bucket_hist[bidx]++;
		for (int i = 0; i < known_count; i++) begin
			if (prefixes_equal(r.src_addr, r.src_len, known_rules[i].src_addr,
					known_rules[i].src_len))
				hit[FieldSrc] = 1'b1;
			if (prefixes_equal(r.dst_addr, r.dst_len, known_rules[i].dst_addr,
					known_rules[i].dst_len))
				hit[FieldDst] = 1'b1;
			if (r.sport_low == known_rules[i].sport_low
					&& r.sport_high == known_rules[i].sport_high)
				hit[FieldSport] = 1'b1;
			if (r.dport_low == known_rules[i].dport_low
					&& r.dport_high == known_rules[i].dport_high)
				hit[FieldDport] = 1'b1;
			if (r.proto_low == known_rules[i].proto_low
					&& r.proto_high == known_rules[i].proto_high)
				hit[FieldProto] = 1'b1;
		end
		v.new_field_mask = ~hit;
		v.table_full = 1'b0;
		if (v.new_field_mask != '0) begin
			if (known_count >= rfdt_pkg::TableDepth) begin
				v.table_full = 1'b1;
			end else begin
				known_rules[known_count] = r;
				known_count++;
				for (int f = 0; f < NumFields; f++)
					if (v.new_field_mask[f])
						field_seen[f]++;
			end
		end
		v.bucket_index = bidx[12:0];
		v.bucket_count = bucket_hist[bidx][15:0];
		v.distinct_src = field_seen[FieldSrc][10:0];
		v.distinct_dst = field_seen[FieldDst][10:0];
		v.distinct_sport = field_seen[FieldSport][10:0];
		v.distinct_dport = field_seen[FieldDport][10:0];
		v.distinct_proto = field_seen[FieldProto][10:0];
		return v;
	endfunction

	// send one rule beat; valid stays up across back-to-back beats
	task automatic send_rule(rule_t r);
		int gap;
		gap = $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		drv <= r;
		do
			@(posedge clk);
		while (!in_ready);
		pending_verdicts.push_back(classify_rule(r));
	endtask

	// drop valid, then wait for every outstanding result beat
	task automatic drain_verdicts();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	function automatic rule_t random_rule(bit fresh);
		rule_t r;
		rule_t k;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(rule_t)-1:0];
		r.src_len = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
			: 6'($urandom_range(0, 32));
		r.dst_len = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
			: 6'($urandom_range(0, 32));
		if ($urandom_range(0, 3) == 0)
			r.sport_high = r.sport_low;
		if ($urandom_range(0, 3) == 0)
			r.dport_high = r.dport_low;
		if ($urandom_range(0, 3) == 0)
			r.proto_high = r.proto_low;
		// reuse fields of stored rules so matches happen often
		if (!fresh && known_count > 0) begin
			k = known_rules[$urandom_range(0, known_count - 1)];
			if ($urandom_range(0, 1)) begin
				r.src_addr = k.src_addr ^ ($urandom & 32'h0000_00FF);
				r.src_len = k.src_len;
			end
			if ($urandom_range(0, 1)) begin
				r.dst_addr = k.dst_addr;
				r.dst_len = k.dst_len;
			end
			if ($urandom_range(0, 1)) begin
				r.sport_low = k.sport_low;
				r.sport_high = k.sport_high;
			end
			if ($urandom_range(0, 1)) begin
				r.dport_low = k.dport_low;
				r.dport_high = k.dport_high;
			end
			if ($urandom_range(0, 2) != 0) begin
				r.proto_low = k.proto_low;
				r.proto_high = k.proto_high;
			end
			if ($urandom_range(0, 9) == 0)
				r = k;
		end
		return r;
	endfunction

	task automatic test_directed();
		rule_t r;
		send_rule('1);
		r = '1;
		r.src_len = 6'd32;
		r.dst_len = 6'd33;
		send_rule(r);
		r = '0;
		r.src_addr = 32'hDEAD_BEEF;
		r.dst_addr = 32'h1234_5678;
		send_rule(r);
		r = '0;
		r.src_addr = 32'hC0A8_0100;
		r.src_len = 6'd24;
		r.dst_addr = 32'h0A00_0000;
		r.dst_len = 6'd8;
		r.sport_high = 16'hFFFF;
		r.dport_low = 16'd80;
		r.dport_high = 16'd80;
		r.proto_low = 8'd6;
		r.proto_high = 8'd6;
		send_rule(r);
		// same prefixes, low bits differ
		r.src_addr = 32'hC0A8_01FF;
		r.dst_addr = 32'h0AFF_FFFF;
		send_rule(r);
		// inverted ranges
		r.sport_low = 16'hFFFF;
		r.sport_high = 16'h0000;
		r.dport_low = 16'd1024;
		r.dport_high = 16'd1;
		r.proto_low = 8'hFF;
		r.proto_high = 8'h00;
		send_rule(r);
		// one-bit prefixes differing in the top bit
		r.src_addr = 32'h8000_0000;
		r.src_len = 6'd1;
		r.dst_addr = 32'h0000_0000;
		r.dst_len = 6'd1;
		send_rule(r);
		r.src_addr = 32'h7FFF_FFFF;
		r.dst_addr = 32'hFFFF_FFFF;
		send_rule(r);
		// over-long lengths clamp onto the /32 entries
		r = '1;
		r.src_len = 6'd40;
		r.dst_len = 6'd32;
		send_rule(r);
		r.src_len = 6'd32;
		r.dst_len = 6'd63;
		r.src_addr = 32'hFFFF_FFFE;
		send_rule(r);
		r = '0;
		r.proto_low = 8'h00;
		r.proto_high = 8'hFF;
		r.sport_low = 16'h0001;
		r.sport_high = 16'h0001;
		r.dport_low = 16'h0000;
		r.dport_high = 16'hFFFF;
		send_rule(r);
		send_rule(r);
		drain_verdicts();
	endtask

	task automatic test_random();
		for (int n = 0; n < 580; n++) begin
			send_rule(random_rule($urandom_range(0, 3) == 0));
			if (n == 290)
				drain_verdicts();
		end
		drain_verdicts();
	endtask

	task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name,
				exp_v, act_v);
		end
	endtask

	// result check and idle watchdog
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("[rule_field_distinct_tracker] ERROR");
				$finish;
			end
		end
		if (out_valid && out_ready) begin
			stall_left = $urandom_range(0, 9);
			if (pending_verdicts.size() == 0) begin
				fail_count++;
				$display("%0t unexpected result beat: actual %p", $time, got);
			end else begin
				want = pending_verdicts.pop_front();
				compare_field("new_field_mask", 16'(want.new_field_mask),
					16'(got.new_field_mask));
				compare_field("bucket_index", 16'(want.bucket_index),
					16'(got.bucket_index));
				compare_field("bucket_count", want.bucket_count, got.bucket_count);
				compare_field("distinct_src", 16'(want.distinct_src),
					16'(got.distinct_src));
				compare_field("distinct_dst", 16'(want.distinct_dst),
					16'(got.distinct_dst));
				compare_field("distinct_sport", 16'(want.distinct_sport),
					16'(got.distinct_sport));
				compare_field("distinct_dport", 16'(want.distinct_dport),
					16'(got.distinct_dport));
				compare_field("distinct_proto", 16'(want.distinct_proto),
					16'(got.distinct_proto));
				compare_field("table_full", 16'(want.table_full), 16'(got.table_full));
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		drv = '0;
		known_count = 0;
		fail_count = 0;
		idle_cycles = 0;
		stall_left = 0;
		foreach (bucket_hist[i])
			bucket_hist[i] = 0;
		foreach (field_seen[i])
			field_seen[i] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		@(negedge clk);
		in_valid <= 1'b0;
		drain_verdicts();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("[rule_field_distinct_tracker] OK");
		else
			$display("[rule_field_distinct_tracker] ERROR");
		$finish;
	end
endmodule
